FILE: design/ordered_array_insert_delete_defines.svh
// Assertion macros used by the checker of the ordered array block.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH
`define ORDERED_ARRAY_INSERT_DELETE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OAID_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define OAID_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/oaid_pkg.sv
// Shared constants and types of the ordered array block.
// Used by the element store, the top level and the checker; depends on nothing.
package oaid_pkg;

  // Store geometry.
  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int CAP_W  = 7;
  localparam int OP_W   = 3;
  localparam int ST_W   = 2;

  // Command codes.
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_EDIT   = 3'd3;
  localparam logic [OP_W-1:0] OP_GET    = 3'd4;

  // Status codes.
  localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE = 2'd2;

  // Write request into the element store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } wr_req_t;

  // Read request into the element store.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } rd_req_t;

endpackage

FILE: design/oaid_store.sv
// Element store of the ordered array: one write port, one registered read port.
// Depends on oaid_pkg for geometry and request types.
module oaid_store (
  input  logic                         clk,
  input  oaid_pkg::wr_req_t            wr_req,
  input  oaid_pkg::rd_req_t            rd_req,
  output logic [oaid_pkg::DATA_W-1:0]  rd_data
);

  logic [oaid_pkg::DATA_W-1:0] mem [oaid_pkg::DEPTH];
  logic [oaid_pkg::DATA_W-1:0] rd_data_r;

  // Write and registered read; entries hold nothing useful until written.
  always_ff @(posedge clk) begin
    if (wr_req.en) begin
      mem[wr_req.addr] <= wr_req.data;
    end
    if (rd_req.en) begin
      rd_data_r <= mem[rd_req.addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: design/ordered_array_insert_delete.sv
// Ordered array list with insert and delete by shifting, top level.
// Depends on oaid_pkg and oaid_store.
//
// Usage:
//   A command item is taken at a rising edge with start high and busy low.
//   Its result (read value, status, element count) shows on the out_ ports
//   for exactly one cycle with out_valid high; the receiver cannot stall.
//   The capacity register is written over cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high. Write it only while the block is idle.
// Steps from accept to result:
//   rejected command, append, edit, insert at the end, delete of the
//   last element: result registered at the accepting edge. Get: S_GET_WAIT.
//   Insert at position p: S_UP_RD and S_UP_WR per moved element, then S_PUT.
//   Delete at position p: S_DN_RD and S_DN_WR per moved element.
//   Every moved element takes one read and one write on the single port pair.
//   busy is high from the cycle after accept up to the cycle before the
//   result, so the next item can be taken in the result cycle.
// Reset (rst_n low, synchronous) empties the list and sets the capacity to
// 64; no clearing pass runs, since no entry is read before it is written.
module ordered_array_insert_delete (
  input  logic                                clk,
  input  logic                                rst_n,
  // Command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [oaid_pkg::OP_W-1:0]           in_operation,
  input  logic [oaid_pkg::ADDR_W-1:0]         in_position,
  input  logic signed [oaid_pkg::DATA_W-1:0]  in_write_value,
  // Result channel
  output logic                                out_valid,
  output logic signed [oaid_pkg::DATA_W-1:0]  out_read_value,
  output logic [oaid_pkg::ST_W-1:0]           out_status,
  output logic [oaid_pkg::CNT_W-1:0]          out_element_count,
  // Configuration channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [oaid_pkg::CAP_W-1:0]          cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_WR,
    S_PUT,
    S_DN_RD,
    S_DN_WR,
    S_GET_WAIT
  } state_t;

  state_t                          state_r;
  logic [oaid_pkg::CNT_W-1:0]      count_r;
  logic [oaid_pkg::CAP_W-1:0]      capacity_r;
  logic [oaid_pkg::ADDR_W-1:0]     idx_r;
  logic [oaid_pkg::ADDR_W-1:0]     pos_r;
  logic [oaid_pkg::DATA_W-1:0]     val_r;
  logic                            out_valid_r;
  logic [oaid_pkg::DATA_W-1:0]     out_read_r;
  logic [oaid_pkg::ST_W-1:0]       out_status_r;
  logic [oaid_pkg::CNT_W-1:0]      out_count_r;

  logic                            accept;
  logic [oaid_pkg::CNT_W-1:0]      cap_now;
  logic [oaid_pkg::CNT_W-1:0]      pos_ext;
  logic                            is_full;
  logic                            pos_lt_cnt;
  logic                            pos_le_cnt;
  logic [oaid_pkg::ADDR_W-1:0]     idx_dec;
  logic [oaid_pkg::ADDR_W-1:0]     idx_inc;
  logic                            dn_last;
  logic [oaid_pkg::DATA_W-1:0]     rd_data;
  oaid_pkg::wr_req_t               wr_req;
  oaid_pkg::rd_req_t               rd_req;

  // Command qualification against the current count and capacity.
  assign accept  = start && (state_r == S_IDLE);
  assign cap_now = (oaid_pkg::CNT_W'(capacity_r) > oaid_pkg::CNT_W'(oaid_pkg::DEPTH))
                   ? oaid_pkg::CNT_W'(oaid_pkg::DEPTH) : oaid_pkg::CNT_W'(capacity_r);
  assign pos_ext    = oaid_pkg::CNT_W'(in_position);
  assign is_full    = count_r >= cap_now;
  assign pos_lt_cnt = pos_ext < count_r;
  assign pos_le_cnt = pos_ext <= count_r;
  assign idx_dec    = idx_r - oaid_pkg::ADDR_W'(1);
  assign idx_inc    = idx_r + oaid_pkg::ADDR_W'(1);
  // Delete walk ends once the element just moved down was the last one.
  assign dn_last    = (oaid_pkg::CNT_W'(idx_r) + oaid_pkg::CNT_W'(2)) == count_r;

  // Store requests for each step of the sequencer.
  always_comb begin
    wr_req = '0;
    rd_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          unique case (in_operation)
            oaid_pkg::OP_INSERT: begin
              if (!is_full && pos_ext == count_r) begin
                wr_req = {1'b1, count_r[oaid_pkg::ADDR_W-1:0], in_write_value};
              end
            end
            oaid_pkg::OP_APPEND: begin
              if (!is_full) begin
                wr_req = {1'b1, count_r[oaid_pkg::ADDR_W-1:0], in_write_value};
              end
            end
            oaid_pkg::OP_EDIT: begin
              if (pos_lt_cnt) begin
                wr_req = {1'b1, in_position, in_write_value};
              end
            end
            oaid_pkg::OP_GET: begin
              if (pos_lt_cnt) begin
                rd_req = {1'b1, in_position};
              end
            end
            default: begin
              wr_req = '0;
            end
          endcase
        end
      end
      S_UP_RD:    rd_req = {1'b1, idx_dec};
      S_UP_WR:    wr_req = {1'b1, idx_r, rd_data};
      S_PUT:      wr_req = {1'b1, pos_r, val_r};
      S_DN_RD:    rd_req = {1'b1, idx_inc};
      S_DN_WR:    wr_req = {1'b1, idx_r, rd_data};
      S_GET_WAIT: rd_req = '0;
      default:    rd_req = '0;
    endcase
  end

  // Sequencer, list state and registered result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      capacity_r  <= oaid_pkg::CAP_W'(oaid_pkg::DEPTH);
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid) begin
        capacity_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            pos_r        <= in_position;
            val_r        <= in_write_value;
            out_read_r   <= '0;
            out_status_r <= oaid_pkg::ST_DONE;
            out_count_r  <= count_r;
            out_valid_r  <= 1'b1;
            unique case (in_operation)
              oaid_pkg::OP_INSERT: begin
                if (is_full) begin
                  out_status_r <= oaid_pkg::ST_FULL;
                end else if (!pos_le_cnt) begin
                  out_status_r <= oaid_pkg::ST_RANGE;
                end else if (pos_ext == count_r) begin
                  count_r     <= count_r + oaid_pkg::CNT_W'(1);
                  out_count_r <= count_r + oaid_pkg::CNT_W'(1);
                end else begin
                  idx_r       <= count_r[oaid_pkg::ADDR_W-1:0];
                  out_valid_r <= 1'b0;
                  state_r     <= S_UP_RD;
                end
              end
              oaid_pkg::OP_APPEND: begin
                if (is_full) begin
                  out_status_r <= oaid_pkg::ST_FULL;
                end else begin
                  count_r     <= count_r + oaid_pkg::CNT_W'(1);
                  out_count_r <= count_r + oaid_pkg::CNT_W'(1);
                end
              end
              oaid_pkg::OP_DELETE: begin
                if (!pos_lt_cnt) begin
                  out_status_r <= oaid_pkg::ST_RANGE;
                end else if (pos_ext + oaid_pkg::CNT_W'(1) == count_r) begin
                  count_r     <= count_r - oaid_pkg::CNT_W'(1);
                  out_count_r <= count_r - oaid_pkg::CNT_W'(1);
                end else begin
                  idx_r       <= in_position;
                  out_valid_r <= 1'b0;
                  state_r     <= S_DN_RD;
                end
              end
              oaid_pkg::OP_EDIT: begin
                if (!pos_lt_cnt) begin
                  out_status_r <= oaid_pkg::ST_RANGE;
                end
              end
              oaid_pkg::OP_GET: begin
                if (!pos_lt_cnt) begin
                  out_status_r <= oaid_pkg::ST_RANGE;
                end else begin
                  out_valid_r <= 1'b0;
                  state_r     <= S_GET_WAIT;
                end
              end
              default: begin
                out_status_r <= oaid_pkg::ST_RANGE;
              end
            endcase
          end
        end
        S_UP_RD: begin
          state_r <= S_UP_WR;
        end
        S_UP_WR: begin
          idx_r   <= idx_dec;
          state_r <= (idx_dec == pos_r) ? S_PUT : S_UP_RD;
        end
        S_PUT: begin
          count_r     <= count_r + oaid_pkg::CNT_W'(1);
          out_count_r <= count_r + oaid_pkg::CNT_W'(1);
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        S_DN_RD: begin
          state_r <= S_DN_WR;
        end
        S_DN_WR: begin
          idx_r <= idx_inc;
          if (dn_last) begin
            count_r     <= count_r - oaid_pkg::CNT_W'(1);
            out_count_r <= count_r - oaid_pkg::CNT_W'(1);
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end else begin
            state_r <= S_DN_RD;
          end
        end
        S_GET_WAIT: begin
          out_read_r  <= rd_data;
          out_valid_r <= 1'b1;
          state_r     <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  oaid_store u_store (
    .clk     (clk),
    .wr_req  (wr_req),
    .rd_req  (rd_req),
    .rd_data (rd_data)
  );

  assign busy              = (state_r != S_IDLE);
  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_read_value    = out_read_r;
  assign out_status        = out_status_r;
  assign out_element_count = out_count_r;

endmodule

FILE: design/oaid_checker.sv
// Port-level checker of the ordered array block, bound to the top level.
// Depends on oaid_pkg and ordered_array_insert_delete_defines.svh.
`include "ordered_array_insert_delete_defines.svh"

module oaid_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic                                out_valid,
  input  logic signed [oaid_pkg::DATA_W-1:0]  out_read_value,
  input  logic [oaid_pkg::ST_W-1:0]           out_status,
  input  logic [oaid_pkg::CNT_W-1:0]          out_element_count
);

  // An accepted item either answers at once or keeps the block busy.
  `OAID_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "item neither answered nor busy")

  // A result never shows while a command is still in work.
  `OAID_ASSERT_NOW(a_no_result_when_busy, busy, !out_valid, "result shown while busy")

  // The count never exceeds the store depth.
  `OAID_ASSERT_NOW(a_count_bound, out_valid, out_element_count <= oaid_pkg::CNT_W'(oaid_pkg::DEPTH), "element count beyond depth")

  // A rejected command reads back zero.
  `OAID_ASSERT_NOW(a_reject_zero, out_valid && out_status != oaid_pkg::ST_DONE, out_read_value == 0, "rejected command returned data")

endmodule

bind ordered_array_insert_delete oaid_checker u_oaid_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .start             (start),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_read_value    (out_read_value),
  .out_status        (out_status),
  .out_element_count (out_element_count)
);

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ordered array list block (insert, append, delete, edit, get).
// It keeps its own copy of the list state and compares every result with it.
// Depends on oaid_pkg and the top level ordered_array_insert_delete.
module testbench;

  localparam int STALL_LIMIT = 1000;

  // One expected or observed result item.
  typedef struct {
    logic signed [oaid_pkg::DATA_W-1:0] read_value;
    logic [oaid_pkg::ST_W-1:0]          status;
    logic [oaid_pkg::CNT_W-1:0]         element_count;
  } list_result_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               start = 1'b0;
  logic                               busy;
  logic [oaid_pkg::OP_W-1:0]          in_operation = '0;
  logic [oaid_pkg::ADDR_W-1:0]        in_position = '0;
  logic signed [oaid_pkg::DATA_W-1:0] in_write_value = '0;
  logic                               out_valid;
  logic signed [oaid_pkg::DATA_W-1:0] out_read_value;
  logic [oaid_pkg::ST_W-1:0]          out_status;
  logic [oaid_pkg::CNT_W-1:0]         out_element_count;
  logic                               cfg_valid = 1'b0;
  logic                               cfg_ready;
  logic [oaid_pkg::CAP_W-1:0]         cfg_data = '0;

  // Shadow copy of the list and its capacity register.
  logic signed [oaid_pkg::DATA_W-1:0] shadow_words [oaid_pkg::DEPTH];
  int                                 shadow_count = 0;
  logic [oaid_pkg::CAP_W-1:0]         shadow_capacity = 7'd64;

  list_result_t pending_results [$];
  int           error_count = 0;
  int           stall_cycles = 0;
  bit           sender_idling = 1'b1;

  ordered_array_insert_delete u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_position       (in_position),
    .in_write_value    (in_write_value),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_status        (out_status),
    .out_element_count (out_element_count),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Applies one command to the shadow list and returns the result it must produce.
  function automatic list_result_t apply_list_command(
      input logic [oaid_pkg::OP_W-1:0]          op,
      input logic [oaid_pkg::ADDR_W-1:0]        pos,
      input logic signed [oaid_pkg::DATA_W-1:0] value);
    list_result_t res;
    int           limit_now;
    int           p;
    int           i;
    res.read_value = '0;
    res.status     = oaid_pkg::ST_DONE;
    p              = int'(pos);
    limit_now      = (int'(shadow_capacity) < oaid_pkg::DEPTH) ? int'(shadow_capacity)
                                                                : oaid_pkg::DEPTH;
    case (op)
      oaid_pkg::OP_INSERT: begin
        // The full test is made before the position test.
        if (shadow_count >= limit_now) begin
          res.status = oaid_pkg::ST_FULL;
        end else if (p > shadow_count) begin
          res.status = oaid_pkg::ST_RANGE;
        end else begin
          for (i = shadow_count; i > p; i--) shadow_words[i] = shadow_words[i-1];
          shadow_words[p] = value;
          shadow_count++;
        end
      end
      oaid_pkg::OP_APPEND: begin
        if (shadow_count >= limit_now) begin
          res.status = oaid_pkg::ST_FULL;
        end else begin
          shadow_words[shadow_count] = value;
          shadow_count++;
        end
      end
      oaid_pkg::OP_DELETE: begin
        if (p >= shadow_count) begin
          res.status = oaid_pkg::ST_RANGE;
        end else begin
          for (i = p; i + 1 < shadow_count; i++) shadow_words[i] = shadow_words[i+1];
          shadow_count--;
        end
      end
      oaid_pkg::OP_EDIT: begin
        if (p >= shadow_count) res.status = oaid_pkg::ST_RANGE;
        else shadow_words[p] = value;
      end
      oaid_pkg::OP_GET: begin
        if (p >= shadow_count) res.status = oaid_pkg::ST_RANGE;
        else res.read_value = shadow_words[p];
      end
      default: begin
        // Unknown operation codes change nothing.
        res.status = oaid_pkg::ST_RANGE;
      end
    endcase
    res.element_count = oaid_pkg::CNT_W'(shadow_count);
    return res;
  endfunction

  // Sends one command item, with an occasional idle burst before it.
  task automatic issue_command(input logic [oaid_pkg::OP_W-1:0] op,
                               input logic [oaid_pkg::ADDR_W-1:0] pos,
                               input logic signed [oaid_pkg::DATA_W-1:0] value);
    int gap;
    if (sender_idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 17);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_position    <= pos;
    in_write_value <= value;
    do @(posedge clk); while (busy);
    pending_results.push_back(apply_list_command(op, pos, value));
  endtask

  // Blocks until every expected result has come back.
  task automatic wait_list_idle();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes the capacity register while the block is idle.
  task automatic write_capacity(input logic [oaid_pkg::CAP_W-1:0] value);
    start <= 1'b0;
    wait_list_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow_capacity = value;
  endtask

  // Picks a mostly well-formed command for the current list length.
  task automatic issue_random_command(input int grow_percent);
    int                          roll;
    logic [oaid_pkg::OP_W-1:0]   op;
    logic [oaid_pkg::ADDR_W-1:0] pos;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      op = oaid_pkg::OP_W'($urandom_range(0, 7));
    end else if (roll < 5 + grow_percent) begin
      op = ($urandom_range(0, 2) == 0) ? oaid_pkg::OP_APPEND : oaid_pkg::OP_INSERT;
    end else begin
      case ($urandom_range(0, 2))
        0:       op = oaid_pkg::OP_DELETE;
        1:       op = oaid_pkg::OP_EDIT;
        default: op = oaid_pkg::OP_GET;
      endcase
    end
    if ($urandom_range(0, 9) == 0) begin
      pos = oaid_pkg::ADDR_W'($urandom_range(0, oaid_pkg::DEPTH - 1));
    end else if (op == oaid_pkg::OP_INSERT) begin
      pos = oaid_pkg::ADDR_W'($urandom_range(0, (shadow_count < oaid_pkg::DEPTH)
                                                ? shadow_count : oaid_pkg::DEPTH - 1));
    end else if (shadow_count > 0) begin
      pos = oaid_pkg::ADDR_W'($urandom_range(0, shadow_count - 1));
    end else begin
      pos = oaid_pkg::ADDR_W'($urandom_range(0, oaid_pkg::DEPTH - 1));
    end
    issue_command(op, pos, $urandom);
  endtask

  // Commands on an empty list are all rejected except for growth.
  task automatic test_empty_list();
    issue_command(oaid_pkg::OP_GET, 6'd0, 32'sd0);
    issue_command(oaid_pkg::OP_DELETE, 6'd0, 32'sd0);
    issue_command(oaid_pkg::OP_EDIT, 6'd0, 32'sh1234_5678);
    issue_command(oaid_pkg::OP_INSERT, 6'd1, 32'sd7);
    issue_command(oaid_pkg::OP_INSERT, 6'd63, 32'sd7);
    issue_command(3'd5, 6'd0, 32'sd1);
    issue_command(3'd6, 6'd21, 32'sd1);
    issue_command(3'd7, 6'd42, -32'sd1);
  endtask

  // Each operation at the extremes of position and value.
  task automatic test_basic_operations();
    issue_command(oaid_pkg::OP_APPEND, 6'd63, 32'sh7FFF_FFFF);
    issue_command(oaid_pkg::OP_APPEND, 6'd0, 32'sh8000_0000);
    issue_command(oaid_pkg::OP_INSERT, 6'd0, -32'sd1);
    issue_command(oaid_pkg::OP_INSERT, 6'd3, 32'sd0);
    issue_command(oaid_pkg::OP_GET, 6'd0, 32'sd0);
    issue_command(oaid_pkg::OP_GET, 6'd3, 32'sd0);
    issue_command(oaid_pkg::OP_EDIT, 6'd1, 32'sh5555_AAAA);
    issue_command(oaid_pkg::OP_GET, 6'd1, 32'sd0);
    issue_command(oaid_pkg::OP_DELETE, 6'd0, 32'sd0);
    issue_command(oaid_pkg::OP_DELETE, 6'd2, 32'sd0);
    issue_command(oaid_pkg::OP_GET, 6'd63, 32'sd0);
    issue_command(oaid_pkg::OP_DELETE, 6'd63, 32'sd0);
    issue_command(3'd7, 6'd63, 32'sh7FFF_FFFF);
  endtask

  // Zero capacity and a capacity lowered below the current length.
  task automatic test_capacity_edges();
    write_capacity(7'd0);
    issue_command(oaid_pkg::OP_APPEND, 6'd0, 32'sd5);
    issue_command(oaid_pkg::OP_INSERT, 6'd63, 32'sd5);
    write_capacity(7'd1);
    issue_command(oaid_pkg::OP_APPEND, 6'd0, 32'sd9);
    issue_command(oaid_pkg::OP_GET, 6'd1, 32'sd0);
  endtask

  // Capacity above the store depth: fill completely, then empty by deletes.
  task automatic test_fill_to_store_depth();
    write_capacity(7'd127);
    while (shadow_count < oaid_pkg::DEPTH) begin
      if ($urandom_range(0, 3) == 0) begin
        issue_command(oaid_pkg::OP_APPEND, oaid_pkg::ADDR_W'($urandom), $urandom);
      end else begin
        issue_command(oaid_pkg::OP_INSERT,
                      oaid_pkg::ADDR_W'($urandom_range(0, shadow_count)), $urandom);
      end
    end
    issue_command(oaid_pkg::OP_INSERT, 6'd0, 32'sd3);
    issue_command(oaid_pkg::OP_APPEND, 6'd0, 32'sd3);
    issue_command(oaid_pkg::OP_GET, 6'd63, 32'sd0);
    write_capacity(7'd64);
    issue_command(oaid_pkg::OP_APPEND, 6'd0, 32'sd4);
    write_capacity(7'd5);
    issue_command(oaid_pkg::OP_INSERT, 6'd10, 32'sd4);
    while (shadow_count > 0) begin
      issue_command(oaid_pkg::OP_DELETE,
                    oaid_pkg::ADDR_W'($urandom_range(0, shadow_count - 1)), $urandom);
    end
  endtask

  // Phases of random commands, each under a new capacity setting.
  task automatic test_random_commands(input int phases, input int items_per_phase);
    int                         phase;
    int                         n;
    int                         grow_percent;
    logic [oaid_pkg::CAP_W-1:0] capacity;
    for (phase = 0; phase < phases; phase++) begin
      case ($urandom_range(0, 9))
        0:       capacity = 7'd0;
        1:       capacity = 7'd127;
        2:       capacity = 7'd64;
        3:       capacity = 7'd1;
        default: capacity = oaid_pkg::CAP_W'($urandom_range(1, 127));
      endcase
      write_capacity(capacity);
      grow_percent = (phase % 2 == 0) ? 60 : 30;
      for (n = 0; n < items_per_phase; n++) issue_random_command(grow_percent);
    end
  endtask

  // Result checker: every result must match the oldest expectation.
  always @(posedge clk) begin : result_check
    list_result_t expected_item;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: read_value %0d status %0d element_count %0d",
               out_read_value, out_status, out_element_count);
        error_count++;
      end else begin
        expected_item = pending_results.pop_front();
        if (out_read_value !== expected_item.read_value) begin
          $error("read_value: expected %0d, actual %0d", expected_item.read_value,
                 out_read_value);
          error_count++;
        end
        if (out_status !== expected_item.status) begin
          $error("status: expected %0d, actual %0d", expected_item.status, out_status);
          error_count++;
        end
        if (out_element_count !== expected_item.element_count) begin
          $error("element_count: expected %0d, actual %0d", expected_item.element_count,
                 out_element_count);
          error_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which no item, result or register write is taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_list();
    test_basic_operations();
    test_capacity_edges();
    test_fill_to_store_depth();
    test_random_commands(20, 50);
    // Last stretch runs without idle bursts.
    sender_idling = 1'b0;
    test_random_commands(4, 50);
    start <= 1'b0;
    wait_list_idle();
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/oaid_pkg.sv
design/oaid_store.sv
design/ordered_array_insert_delete.sv
design/oaid_checker.sv
verif/testbench.sv
